// ===== rtl/sha_pkg.sv =====
// sha_pkg: shared types, constants and state codes for the sha-256 message hash
// used by sha_wram, sha_core and sha256_message_hash; no dependencies
`default_nettype none

package sha_pkg;

    localparam int WIN_DEPTH = 16;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int ROUNDS    = 64;

    localparam logic [7:0]        PAD_BYTE = 8'h80;
    localparam logic [WIN_AW-1:0] LEN_SLOT = 4'd14;
    localparam logic [WIN_AW-1:0] LAST_SLOT = 4'd15;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        final_item;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    typedef enum logic [2:0] {
        ST_IN,
        ST_PAD,
        ST_ZERO,
        ST_LEN_LO,
        ST_COMP,
        ST_OUT
    } t_state;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

// ===== rtl/sha_wram.sv =====
// sha_wram: 16-word message block memory, one write and one registered read port
// depends on sha_pkg
`default_nettype none

module sha_wram (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [sha_pkg::WIN_AW-1:0] i_waddr,
    input  wire sha_pkg::t_word            i_wdata,
    input  wire logic                      i_re,
    input  wire logic [sha_pkg::WIN_AW-1:0] i_raddr,
    output sha_pkg::t_word                 o_rdata
);

    sha_pkg::t_word r_mem [sha_pkg::WIN_DEPTH];
    sha_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/sha_core.sv =====
// sha_core: 64-round compression, one round per cycle, with the chaining value
// reads the block from sha_wram; depends on sha_pkg
`default_nettype none

module sha_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sha_pkg::t_core_ctl         i_ctl,
    output sha_pkg::t_core_sts              o_sts,
    output logic                            o_re,
    output logic [sha_pkg::WIN_AW-1:0]      o_raddr,
    input  wire sha_pkg::t_word             i_rdata,
    output sha_pkg::t_word                  o_chain [8]
);

    logic           r_busy;
    logic           r_fin;
    logic [5:0]     r_cnt;
    sha_pkg::t_word r_chain [8];
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_win [sha_pkg::WIN_DEPTH];

    sha_pkg::t_word w_exp, w_wt, w_s0, w_s1, w_big0, w_big1, w_ch, w_maj, w_t1;
    sha_pkg::t_word w_x, w_y, w_a, w_e;

    always_comb begin
        w_x    = r_win[1];
        w_y    = r_win[14];
        w_s0   = {w_x[6:0], w_x[31:7]} ^ {w_x[17:0], w_x[31:18]} ^ (w_x >> 3);
        w_s1   = {w_y[16:0], w_y[31:17]} ^ {w_y[18:0], w_y[31:19]} ^ (w_y >> 10);
        w_exp  = w_s1 + r_win[9] + w_s0 + r_win[0];
        w_wt   = (r_cnt < 6'd16) ? i_rdata : w_exp;
        w_a    = r_v[0];
        w_e    = r_v[4];
        w_big1 = {w_e[5:0], w_e[31:6]} ^ {w_e[10:0], w_e[31:11]} ^ {w_e[24:0], w_e[31:25]};
        w_ch   = (w_e & r_v[5]) ^ (~w_e & r_v[6]);
        w_t1   = r_v[7] + w_big1 + w_ch + sha_pkg::ROUND_K[r_cnt] + w_wt;
        w_big0 = {w_a[1:0], w_a[31:2]} ^ {w_a[12:0], w_a[31:13]} ^ {w_a[21:0], w_a[31:22]};
        w_maj  = (w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]);
    end

    // prefetch the next block word in the cycle before its round
    assign o_re    = i_ctl.start | (r_busy & (r_cnt < 6'd15));
    assign o_raddr = i_ctl.start ? '0 : (r_cnt[sha_pkg::WIN_AW-1:0] + 4'd1);

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_fin;
    assign o_chain    = r_chain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_cnt   <= '0;
            r_chain <= sha_pkg::INIT_HASH;
        end else begin
            if (i_ctl.init) begin
                r_chain <= sha_pkg::INIT_HASH;
            end
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(sha_pkg::ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_fin <= 1'b0;
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= r_chain;
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_big0 + w_maj;
            for (int i = 0; i < sha_pkg::WIN_DEPTH - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[sha_pkg::WIN_DEPTH-1] <= w_wt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sha256_message_hash.sv =====
// sha256_message_hash: top level, word intake, padding, length and digest output
// depends on sha_pkg, sha_wram and sha_core
//
//  channel  dir  handshake                   payload
//  in       in   i_in_valid / o_in_stall     i_in_item  (data_word, valid_bytes, final_item)
//  out      out  o_out_valid / i_out_stall   o_out_item (digest_word, word_index, last_word)
//
// each message word is written into the block memory as it is accepted
// a full block then passes through the round unit (start, 64 rounds, chain add),
// and the input is stalled until the round unit is done with that block
// the final item adds the padding words and one or two more compressions,
// then eight digest items, one per cycle while out is not stalled
// reset is synchronous and active low; the next message is taken while the last
// digest item still waits in the output register
`default_nettype none

module sha256_message_hash (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sha_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output sha_pkg::t_out_item     o_out_item
);

    sha_pkg::t_state               r_state, n_state;
    sha_pkg::t_state               r_ret, n_ret;
    logic [sha_pkg::WIN_AW-1:0]    r_slot;
    logic [63:0]                   r_bit_count;
    logic [2:0]                    r_oidx;
    logic                          r_out_valid;
    sha_pkg::t_out_item            r_out_item;

    sha_pkg::t_state               w_after;
    logic                          w_accept;
    logic                          w_push;
    sha_pkg::t_word                w_push_data;
    logic                          w_load_out;
    logic                          w_msg_done;
    logic [2:0]                    w_nbytes;
    logic                          w_last;
    sha_pkg::t_word                w_short;
    sha_pkg::t_word                w_data;

    sha_pkg::t_core_ctl            w_ctl;
    sha_pkg::t_core_sts            w_sts;
    logic                          w_re;
    logic [sha_pkg::WIN_AW-1:0]    w_raddr;
    sha_pkg::t_word                w_rdata;
    sha_pkg::t_word                w_chain [8];

    sha_wram u_wram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_slot),
        .i_wdata (w_push_data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_re    (w_re),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata),
        .o_chain (w_chain)
    );

    always_comb begin
        w_data   = i_in_item.data_word;
        w_nbytes = (i_in_item.valid_bytes > 3'd4) ? 3'd4 : i_in_item.valid_bytes;
        w_last   = i_in_item.final_item | (w_nbytes != 3'd4);
        unique case (w_nbytes)
            3'd0:    w_short = {sha_pkg::PAD_BYTE, 24'h0};
            3'd1:    w_short = {w_data[31:24], sha_pkg::PAD_BYTE, 16'h0};
            3'd2:    w_short = {w_data[31:16], sha_pkg::PAD_BYTE, 8'h0};
            3'd3:    w_short = {w_data[31:8], sha_pkg::PAD_BYTE};
            default: w_short = w_data;
        endcase
    end

    assign o_in_stall = (r_state != sha_pkg::ST_IN);
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        w_after     = r_state;
        w_push      = 1'b0;
        w_push_data = '0;
        w_load_out  = 1'b0;
        w_msg_done  = 1'b0;
        w_ctl       = '0;
        unique case (r_state)
            sha_pkg::ST_IN: begin
                if (i_in_valid) begin
                    w_push = 1'b1;
                    if (!w_last) begin
                        w_push_data = w_data;
                        w_after     = sha_pkg::ST_IN;
                    end else if (w_nbytes == 3'd4) begin
                        w_push_data = w_data;
                        w_after     = sha_pkg::ST_PAD;
                    end else begin
                        w_push_data = w_short;
                        w_after     = sha_pkg::ST_ZERO;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                w_push      = 1'b1;
                w_push_data = {sha_pkg::PAD_BYTE, 24'h0};
                w_after     = sha_pkg::ST_ZERO;
            end
            sha_pkg::ST_ZERO: begin
                w_push = 1'b1;
                if (r_slot == sha_pkg::LEN_SLOT) begin
                    w_push_data = r_bit_count[63:32];
                    w_after     = sha_pkg::ST_LEN_LO;
                end else begin
                    w_push_data = '0;
                    w_after     = sha_pkg::ST_ZERO;
                end
            end
            sha_pkg::ST_LEN_LO: begin
                w_push      = 1'b1;
                w_push_data = r_bit_count[31:0];
                w_after     = sha_pkg::ST_OUT;
            end
            sha_pkg::ST_COMP: begin
                if (w_sts.done) begin
                    n_state = r_ret;
                end
            end
            sha_pkg::ST_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    if (r_oidx == 3'd7) begin
                        w_msg_done = 1'b1;
                        n_state    = sha_pkg::ST_IN;
                    end
                end
            end
            default: n_state = sha_pkg::ST_IN;
        endcase
        // a write into the last slot completes the block
        if (w_push) begin
            if (r_slot == sha_pkg::LAST_SLOT) begin
                w_ctl.start = 1'b1;
                n_state     = sha_pkg::ST_COMP;
                n_ret       = w_after;
            end else begin
                n_state = w_after;
            end
        end
        w_ctl.init = w_msg_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha_pkg::ST_IN;
            r_ret       <= sha_pkg::ST_IN;
            r_slot      <= '0;
            r_bit_count <= '0;
            r_oidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            if (w_push) begin
                r_slot <= r_slot + 4'd1;
            end
            if (w_msg_done) begin
                r_bit_count <= '0;
            end else if (w_accept) begin
                r_bit_count <= r_bit_count + {58'd0, w_nbytes, 3'b000};
            end
            if (w_load_out) begin
                r_oidx      <= r_oidx + 3'd1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_item.digest_word <= w_chain[r_oidx];
            r_out_item.word_index  <= r_oidx;
            r_out_item.last_word   <= (r_oidx == 3'd7);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_no_write_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_sts.busy))
        else $error("block memory written while rounds run");

    a_start_wraps_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.start |=> (r_slot == '0) && w_sts.busy)
        else $error("compression started without a full block");

    a_len_lo_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha_pkg::ST_LEN_LO) |-> (r_slot == sha_pkg::LAST_SLOT))
        else $error("length low word not in last slot");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> $past(w_sts.busy))
        else $error("chain update without preceding rounds");

endmodule

`default_nettype wire
